>>> hw/rtl/jrid_pkg.sv
package jrid_pkg;

    // Scan phases of the key search and value copy.
    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_COLON  = 3'd1;
    localparam logic [2:0] PH_VALWS  = 3'd2;
    localparam logic [2:0] PH_QUOTED = 3'd3;
    localparam logic [2:0] PH_BARE   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_D      = 8'h64;

    // Entry 0 holds the first character.
    localparam logic [3:0][7:0] NULL_TEXT = {8'h6C, 8'h6C, 8'h75, 8'h6E};

    localparam logic [7:0] MAX_ID_RESET = 8'd63;
    localparam int         MAX_RESULTS  = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       missing;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] ent;
        logic [2:0]                cnt;
    } bundle_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] kpos;
        logic [7:0] prev;
        logic       start;
        logic [7:0] count;
        logic [7:0] pend_byte;
        logic       pend_valid;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        phase:      PH_SEARCH,
        kpos:       2'd0,
        prev:       8'd0,
        start:      1'b1,
        count:      8'd0,
        pend_byte:  8'd0,
        pend_valid: 1'b0
    };

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

>>> hw/rtl/jrid_step.sv
module jrid_step
(
    input  jrid_pkg::scan_state_t cur_state,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  logic [7:0]            max_id_chars,
    output jrid_pkg::scan_state_t state_next,
    output jrid_pkg::bundle_t     bundle_next
);

    // Returns {key complete, new match position}.
    function automatic logic [2:0] key_step(input logic [1:0] kp, input logic [7:0] c,
                                            input logic [7:0] prev, input logic start);
        logic [2:0] r;
        r = 3'b000;
        if (c == jrid_pkg::CH_QUOTE)
        begin
            if (kp == 2'd3)
                r = 3'b100;
            else if (start || prev == jrid_pkg::CH_LBRACE || prev == jrid_pkg::CH_COMMA ||
                     jrid_pkg::is_ws(prev))
                r = 3'b001;
        end
        else if (kp == 2'd1 && c == jrid_pkg::CH_I)
            r = 3'b010;
        else if (kp == 2'd2 && c == jrid_pkg::CH_D)
            r = 3'b011;
        return r;
    endfunction

    jrid_pkg::scan_state_t s;
    logic       ws;
    logic       term;
    logic [2:0] ks;
    logic       bare_now;
    logic       do_push;
    logic       do_fin;
    logic       nul;
    logic       e0_v;
    logic [7:0] e0_b;
    logic       e1_v;
    logic [7:0] e1_b;
    logic [7:0] count_inc;
    logic [2:0] null_cnt;

    always_comb
    begin
        s        = cur_state;
        ws       = jrid_pkg::is_ws(in_byte);
        term     = ws || in_byte == jrid_pkg::CH_COMMA || in_byte == jrid_pkg::CH_RBRACE ||
                   in_byte == jrid_pkg::CH_RBRACK;
        ks       = 3'b000;
        bare_now = 1'b0;
        do_push  = 1'b0;
        do_fin   = 1'b0;
        nul      = 1'b0;
        e0_v     = 1'b0;
        e0_b     = 8'd0;
        e1_v     = 1'b0;
        e1_b     = 8'd0;
        // A push only happens below the limit, so this never wraps when used.
        count_inc = cur_state.count + 8'd1;

        case (cur_state.phase)
            jrid_pkg::PH_SEARCH:
            begin
                ks = key_step(cur_state.kpos, in_byte, cur_state.prev, cur_state.start);
                if (ks[2])
                begin
                    s.phase = jrid_pkg::PH_COLON;
                    s.kpos  = 2'd0;
                end
                else
                    s.kpos = ks[1:0];
            end
            jrid_pkg::PH_COLON:
            begin
                if (ws)
                    s.phase = jrid_pkg::PH_COLON;
                else if (in_byte == jrid_pkg::CH_COLON)
                    s.phase = jrid_pkg::PH_VALWS;
                else
                begin
                    // The breaking byte restarts the key search on its own.
                    ks = key_step(2'd0, in_byte, cur_state.prev, cur_state.start);
                    s.phase = ks[2] ? jrid_pkg::PH_COLON : jrid_pkg::PH_SEARCH;
                    s.kpos  = ks[2] ? 2'd0 : ks[1:0];
                end
            end
            jrid_pkg::PH_VALWS:
            begin
                if (ws)
                    s.phase = jrid_pkg::PH_VALWS;
                else if (in_byte == jrid_pkg::CH_QUOTE)
                begin
                    if (max_id_chars == 8'd0)
                        s.phase = jrid_pkg::PH_DONE;
                    else
                    begin
                        s.phase = jrid_pkg::PH_QUOTED;
                        do_push = 1'b1;
                        do_fin  = count_inc >= max_id_chars;
                    end
                end
                else
                begin
                    s.phase  = jrid_pkg::PH_BARE;
                    bare_now = 1'b1;
                end
            end
            jrid_pkg::PH_QUOTED:
            begin
                if (cur_state.count >= max_id_chars)
                    do_fin = 1'b1;
                else
                begin
                    do_push = 1'b1;
                    do_fin  = (in_byte == jrid_pkg::CH_QUOTE &&
                               cur_state.prev != jrid_pkg::CH_BSLASH) ||
                              count_inc >= max_id_chars;
                end
            end
            jrid_pkg::PH_BARE:
                bare_now = 1'b1;
            default:
                s.phase = cur_state.phase;
        endcase

        if (bare_now)
        begin
            if (term || cur_state.count >= max_id_chars)
            begin
                if (cur_state.count == 8'd0)
                begin
                    nul     = 1'b1;
                    s.phase = jrid_pkg::PH_DONE;
                end
                else
                    do_fin = 1'b1;
            end
            else
            begin
                do_push = 1'b1;
                do_fin  = count_inc >= max_id_chars;
            end
        end

        if (do_push)
        begin
            if (s.pend_valid)
            begin
                e0_v = 1'b1;
                e0_b = s.pend_byte;
            end
            s.pend_byte  = in_byte;
            s.pend_valid = 1'b1;
            s.count      = count_inc;
        end

        // End of message closes whatever is still open.
        if (in_last)
        begin
            case (s.phase)
                jrid_pkg::PH_SEARCH, jrid_pkg::PH_COLON, jrid_pkg::PH_VALWS:
                    nul = 1'b1;
                jrid_pkg::PH_QUOTED:
                    do_fin = 1'b1;
                jrid_pkg::PH_BARE:
                begin
                    if (s.count == 8'd0)
                        nul = 1'b1;
                    else
                        do_fin = 1'b1;
                end
                default:
                    nul = nul;
            endcase
        end

        if (do_fin)
        begin
            if (s.pend_valid)
            begin
                e1_v = 1'b1;
                e1_b = s.pend_byte;
            end
            s.pend_valid = 1'b0;
            s.phase      = jrid_pkg::PH_DONE;
        end

        s.prev  = in_byte;
        s.start = 1'b0;
        if (in_last)
            s = jrid_pkg::SCAN_RESET;
        state_next = s;

        null_cnt    = (max_id_chars < 8'd4) ? max_id_chars[2:0] : 3'd4;
        bundle_next = '0;
        if (nul)
        begin
            bundle_next.cnt = null_cnt;
            for (int i = 0; i < jrid_pkg::MAX_RESULTS; i++)
            begin
                bundle_next.ent[i].data    = jrid_pkg::NULL_TEXT[i];
                bundle_next.ent[i].last    = (3'(i) + 3'd1) == null_cnt;
                bundle_next.ent[i].missing = 1'b1;
            end
        end
        else if (e0_v)
        begin
            bundle_next.ent[0].data = e0_b;
            bundle_next.ent[1].data = e1_b;
            bundle_next.ent[1].last = 1'b1;
            bundle_next.cnt         = e1_v ? 3'd2 : 3'd1;
        end
        else if (e1_v)
        begin
            bundle_next.ent[0].data = e1_b;
            bundle_next.ent[0].last = 1'b1;
            bundle_next.cnt         = 3'd1;
        end
    end

endmodule

>>> hw/rtl/json_rpc_id_extract_top.sv
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_byte[7:0], in_last
// out       out_valid/ out_stall out_byte[7:0], out_last, id_missing
// cfg       cfg_we               cfg_data[7:0] (max_id_chars, reset 63)
//
// A byte enters an input register, then one scan step moves it into a result
// register that holds up to four result bytes, drained one per cycle unless
// stalled. One input transaction per cycle is sustained while each byte yields
// at most one result and no stall; a "null" default gives up to four bytes.
// Reset clears the scan state and both registers; max_id_chars returns to 63.
// The input register still takes one transaction while a result is stalled.
module json_rpc_id_extract_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic       id_missing,
    input  logic       cfg_we,
    input  logic [7:0] cfg_data
);

    logic [7:0]            max_id_reg;
    logic                  in_valid_reg;
    logic                  in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  in_last_reg;
    jrid_pkg::scan_state_t st_reg;
    jrid_pkg::scan_state_t st_next;
    jrid_pkg::bundle_t     bundle_next;
    jrid_pkg::result_t [jrid_pkg::MAX_RESULTS-1:0] ent_reg;
    logic [2:0]            cnt_reg;
    logic [2:0]            cnt_next;
    logic [1:0]            head_reg;
    logic [1:0]            head_next;
    logic                  in_acc;
    logic                  out_acc;
    logic                  advance;

    jrid_step u_step
    (
        .cur_state    (st_reg),
        .in_byte      (in_byte_reg),
        .in_last      (in_last_reg),
        .max_id_chars (max_id_reg),
        .state_next   (st_next),
        .bundle_next  (bundle_next)
    );

    assign out_valid  = cnt_reg != 3'd0;
    assign out_byte   = ent_reg[head_reg].data;
    assign out_last   = ent_reg[head_reg].last;
    assign id_missing = ent_reg[head_reg].missing;
    assign out_acc    = out_valid && !out_stall;

    // The held byte steps once the result register is empty or empties now.
    assign advance  = in_valid_reg && (cnt_reg == 3'd0 || (cnt_reg == 3'd1 && out_acc));
    assign in_stall = in_valid_reg && !advance;
    assign in_acc   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_acc)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (advance)
        begin
            cnt_next  = bundle_next.cnt;
            head_next = 2'd0;
        end
        else if (out_acc)
        begin
            cnt_next  = cnt_reg - 3'd1;
            head_next = head_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_id_reg   <= jrid_pkg::MAX_ID_RESET;
            in_valid_reg <= 1'b0;
            st_reg       <= jrid_pkg::SCAN_RESET;
            cnt_reg      <= 3'd0;
            head_reg     <= 2'd0;
        end
        else
        begin
            if (cfg_we)
                max_id_reg <= cfg_data;
            in_valid_reg <= in_valid_next;
            if (advance)
                st_reg <= st_next;
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= in_last;
        end
        if (advance)
            ent_reg <= bundle_next.ent;
    end

    a_done_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.phase == jrid_pkg::PH_DONE |-> !st_reg.pend_valid)
        else $error("held byte left over after the id was closed");

    a_pending_counted: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.pend_valid |-> st_reg.count != 8'd0)
        else $error("held byte without a copied count");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> st_reg.phase == jrid_pkg::PH_SEARCH && st_reg.start)
        else $error("scan state not returned to start after the final byte");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !advance |=> cnt_reg == $past(cnt_reg) - 3'd1)
        else $error("result count did not drop by one on an output transaction");

    a_null_text: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && id_missing |-> out_byte == jrid_pkg::NULL_TEXT[0] ||
        out_byte == jrid_pkg::NULL_TEXT[1] || out_byte == jrid_pkg::NULL_TEXT[2])
        else $error("default id byte outside the null text");

endmodule
